@@ sv/point_segment_squared_distance_defines.svh @@
// Assertion macros used by the point-to-segment distance RTL.
// Standalone header; no dependencies.
`ifndef POINT_SEGMENT_SQUARED_DISTANCE_DEFINES_SVH
`define POINT_SEGMENT_SQUARED_DISTANCE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PSD_ASSERT_IMPLIES(lbl, ck, rn, pre, post, msg) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define PSD_ASSERT_NEXT(lbl, ck, rn, pre, post, msg) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) (pre) |=> (post)) \
        else $error(msg);

`endif

@@ sv/psd_pkg.sv @@
// Types and width constants for the point-to-segment squared distance block.
// No dependencies.
package psd_pkg;

    localparam int COORD_BITS  = 12;
    localparam int DIFF_W      = COORD_BITS + 1;      // coordinate differences
    localparam int PROD_W      = 2 * COORD_BITS + 2;  // products of differences
    localparam int SUM_W       = 2 * COORD_BITS + 3;  // dot and cross products
    localparam int MAG_W       = 2 * COORD_BITS + 2;  // squared magnitudes
    localparam int U_W         = 2 * COORD_BITS + 2;  // |cross|
    localparam int NQ_W        = MAG_W;               // divisor |n|^2
    localparam int QB          = MAG_W;               // quotient bits
    localparam int N_W         = 2 * U_W;             // dividend |cross|^2
    localparam int DIST_W      = 25;
    localparam int THRESH_W    = 25;
    localparam int CMP_W       = (MAG_W > THRESH_W) ? MAG_W : THRESH_W;
    localparam int SAT_W       = (MAG_W > DIST_W) ? MAG_W : DIST_W;

    localparam logic [1:0] CASE_A      = 2'd0;
    localparam logic [1:0] CASE_B      = 2'd1;
    localparam logic [1:0] CASE_INNER  = 2'd2;
    localparam logic [1:0] CASE_DEGEN  = 2'd3;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] a_x;
        logic signed [COORD_BITS-1:0] a_y;
        logic signed [COORD_BITS-1:0] b_x;
        logic signed [COORD_BITS-1:0] b_y;
        logic signed [COORD_BITS-1:0] p_x;
        logic signed [COORD_BITS-1:0] p_y;
    } query_t;

    typedef struct packed {
        logic [DIST_W-1:0] squared_distance;
        logic [1:0]        closest_case;
    } result_t;

    // side data carried alongside the divider
    typedef struct packed {
        logic [1:0]       kind;
        logic [MAG_W-1:0] dist_end;
    } tag_t;

endpackage

@@ sv/psd_div_pipe.sv @@
// Pipelined restoring divider, one quotient bit per stage.
// Depends on psd_pkg.
module psd_div_pipe (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        enable,
    input  logic                        in_valid,
    input  logic [psd_pkg::N_W-1:0]     dividend,
    input  logic [psd_pkg::NQ_W-1:0]    divisor,
    input  psd_pkg::tag_t               in_tag,
    output logic                        out_valid,
    output logic [psd_pkg::QB-1:0]      quotient,
    output psd_pkg::tag_t               out_tag
);

    localparam int STAGES = psd_pkg::QB;
    localparam int NQ_W   = psd_pkg::NQ_W;
    localparam int QB     = psd_pkg::QB;

    logic [STAGES-1:0] valid_reg;
    logic [NQ_W-1:0]   rem_reg [STAGES];
    logic [QB-1:0]     lo_reg  [STAGES];
    logic [NQ_W-1:0]   d_reg   [STAGES];
    psd_pkg::tag_t     tag_reg [STAGES];

    logic [NQ_W-1:0]   rem_next [STAGES];
    logic [QB-1:0]     lo_next  [STAGES];
    logic [NQ_W-1:0]   d_next   [STAGES];
    psd_pkg::tag_t     tag_next [STAGES];

    // quotient is known to fit QB bits, so the top half of the dividend
    // is already a valid partial remainder
    for (genvar k = 0; k < STAGES; k++)
    begin : g_stage
        logic [NQ_W-1:0] rem_in;
        logic [QB-1:0]   lo_in;
        logic [NQ_W:0]   trial;
        logic            ge;

        if (k == 0)
        begin : g_first
            assign rem_in      = dividend[psd_pkg::N_W-1:QB];
            assign lo_in       = dividend[QB-1:0];
            assign d_next[k]   = divisor;
            assign tag_next[k] = in_tag;
        end
        else
        begin : g_rest
            assign rem_in      = rem_reg[k-1];
            assign lo_in       = lo_reg[k-1];
            assign d_next[k]   = d_reg[k-1];
            assign tag_next[k] = tag_reg[k-1];
        end

        always_comb
        begin
            trial = {rem_in, lo_in[QB-1]};
            ge    = (trial >= {1'b0, d_next[k]});
            if (ge)
                rem_next[k] = NQ_W'(trial - {1'b0, d_next[k]});
            else
                rem_next[k] = NQ_W'(trial);
            lo_next[k] = {lo_in[QB-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (enable)
            valid_reg <= {valid_reg[STAGES-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (enable)
        begin
            for (int k = 0; k < STAGES; k++)
            begin
                rem_reg[k] <= rem_next[k];
                lo_reg[k]  <= lo_next[k];
                d_reg[k]   <= d_next[k];
                tag_reg[k] <= tag_next[k];
            end
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign quotient  = lo_reg[STAGES-1];
    assign out_tag   = tag_reg[STAGES-1];

endmodule

@@ sv/point_segment_squared_distance.sv @@
// Top level of the point-to-segment squared distance block.
// Depends on psd_pkg, psd_div_pipe and point_segment_squared_distance_defines.svh.
//
// Usage:
//   query channel  : query_valid / query_stall, payload query (a, b, p points).
//   result channel : result_valid / result_stall, payload result
//                    (squared_distance, closest_case).
//   config channel : cfg_valid / cfg_ready / cfg_data writes the degenerate
//                    segment threshold; cfg_ready is always high. Write it
//                    only while no transaction is in flight.
//   A transaction moves on a clock edge with valid high and stall low.
//   Throughput: one query per cycle while result_stall does not hold the
//   pipeline. Stages: five arithmetic stages, one divider stage per quotient
//   bit, one output register. The divider depth sets latency.
//   The whole pipeline advances as one; while a result waits under
//   result_stall every stage holds and query_stall is raised.
//   Reset clears all valid bits and the threshold (to 0); no clearing pass.
`include "point_segment_squared_distance_defines.svh"

module point_segment_squared_distance (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            query_valid,
    output logic                            query_stall,
    input  psd_pkg::query_t                 query,
    output logic                            result_valid,
    input  logic                            result_stall,
    output psd_pkg::result_t                result,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [psd_pkg::THRESH_W-1:0]    cfg_data
);

    localparam int DIFF_W = psd_pkg::DIFF_W;
    localparam int PROD_W = psd_pkg::PROD_W;
    localparam int SUM_W  = psd_pkg::SUM_W;
    localparam int MAG_W  = psd_pkg::MAG_W;
    localparam int U_W    = psd_pkg::U_W;
    localparam int N_W    = psd_pkg::N_W;
    localparam int CMP_W  = psd_pkg::CMP_W;
    localparam int SAT_W  = psd_pkg::SAT_W;
    localparam int DIST_W = psd_pkg::DIST_W;

    localparam logic [SAT_W-1:0] DIST_MAX = SAT_W'({DIST_W{1'b1}});

    // single global enable: stall only backs up from a blocked output
    logic advance;
    assign advance     = !(result_valid && result_stall);
    assign query_stall = !advance;
    assign cfg_ready   = 1'b1;

    // ---------------- threshold register ----------------
    logic [psd_pkg::THRESH_W-1:0] thresh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thresh_reg <= '0;
        else if (cfg_valid && cfg_ready)
            thresh_reg <= cfg_data;
    end

    // ---------------- stage 1: difference vectors ----------------
    // n = b - a, pa = a - p, bp = p - b
    logic                     s1_valid_reg;
    logic signed [DIFF_W-1:0] s1_nx_reg, s1_ny_reg;
    logic signed [DIFF_W-1:0] s1_pax_reg, s1_pay_reg;
    logic signed [DIFF_W-1:0] s1_bpx_reg, s1_bpy_reg;

    // ---------------- stage 2: products ----------------
    logic                     s2_valid_reg;
    logic signed [PROD_W-1:0] s2_dax_reg, s2_day_reg;   // n . pa terms
    logic signed [PROD_W-1:0] s2_dbx_reg, s2_dby_reg;   // n . bp terms
    logic signed [PROD_W-1:0] s2_pax2_reg, s2_pay2_reg;
    logic signed [PROD_W-1:0] s2_bpx2_reg, s2_bpy2_reg;
    logic signed [PROD_W-1:0] s2_nx2_reg, s2_ny2_reg;
    logic signed [PROD_W-1:0] s2_cr1_reg, s2_cr2_reg;   // cross terms

    // ---------------- stage 3: sums and case decision ----------------
    logic                     s3_valid_reg;
    psd_pkg::tag_t            s3_tag_reg;
    logic signed [SUM_W-1:0]  s3_cross_reg;
    logic [MAG_W-1:0]         s3_nq_reg;

    // ---------------- stage 4: |cross| ----------------
    logic                     s4_valid_reg;
    psd_pkg::tag_t            s4_tag_reg;
    logic [U_W-1:0]           s4_u_reg;
    logic [MAG_W-1:0]         s4_nq_reg;

    // ---------------- stage 5: |cross|^2 ----------------
    logic                     s5_valid_reg;
    psd_pkg::tag_t            s5_tag_reg;
    logic [N_W-1:0]           s5_sq_reg;
    logic [MAG_W-1:0]         s5_nq_reg;

    // stage 3 combinational sums
    logic signed [SUM_W-1:0]  dot_a, dot_b, cross_sum;
    logic [MAG_W-1:0]         mag_pa, mag_pb, nq_sum;
    logic                     hit_a, hit_b, degen;
    psd_pkg::tag_t            tag3_next;

    always_comb
    begin
        dot_a     = SUM_W'(s2_dax_reg) + SUM_W'(s2_day_reg);
        dot_b     = SUM_W'(s2_dbx_reg) + SUM_W'(s2_dby_reg);
        cross_sum = SUM_W'(s2_cr1_reg) - SUM_W'(s2_cr2_reg);
        mag_pa    = MAG_W'($unsigned(s2_pax2_reg)) + MAG_W'($unsigned(s2_pay2_reg));
        mag_pb    = MAG_W'($unsigned(s2_bpx2_reg)) + MAG_W'($unsigned(s2_bpy2_reg));
        nq_sum    = MAG_W'($unsigned(s2_nx2_reg)) + MAG_W'($unsigned(s2_ny2_reg));
        hit_a     = (dot_a != '0) && !dot_a[SUM_W-1];
        hit_b     = (dot_b != '0) && !dot_b[SUM_W-1];
        degen     = (CMP_W'(nq_sum) <= CMP_W'(thresh_reg));

        // endpoint tests take priority over the degenerate test
        if (hit_a)
            tag3_next.kind = psd_pkg::CASE_A;
        else if (hit_b)
            tag3_next.kind = psd_pkg::CASE_B;
        else if (degen)
            tag3_next.kind = psd_pkg::CASE_DEGEN;
        else
            tag3_next.kind = psd_pkg::CASE_INNER;

        tag3_next.dist_end = (!hit_a && hit_b) ? mag_pb : mag_pa;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= query_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_nx_reg  <= DIFF_W'(query.b_x) - DIFF_W'(query.a_x);
            s1_ny_reg  <= DIFF_W'(query.b_y) - DIFF_W'(query.a_y);
            s1_pax_reg <= DIFF_W'(query.a_x) - DIFF_W'(query.p_x);
            s1_pay_reg <= DIFF_W'(query.a_y) - DIFF_W'(query.p_y);
            s1_bpx_reg <= DIFF_W'(query.p_x) - DIFF_W'(query.b_x);
            s1_bpy_reg <= DIFF_W'(query.p_y) - DIFF_W'(query.b_y);

            s2_dax_reg  <= PROD_W'(s1_nx_reg)  * PROD_W'(s1_pax_reg);
            s2_day_reg  <= PROD_W'(s1_ny_reg)  * PROD_W'(s1_pay_reg);
            s2_dbx_reg  <= PROD_W'(s1_nx_reg)  * PROD_W'(s1_bpx_reg);
            s2_dby_reg  <= PROD_W'(s1_ny_reg)  * PROD_W'(s1_bpy_reg);
            s2_pax2_reg <= PROD_W'(s1_pax_reg) * PROD_W'(s1_pax_reg);
            s2_pay2_reg <= PROD_W'(s1_pay_reg) * PROD_W'(s1_pay_reg);
            s2_bpx2_reg <= PROD_W'(s1_bpx_reg) * PROD_W'(s1_bpx_reg);
            s2_bpy2_reg <= PROD_W'(s1_bpy_reg) * PROD_W'(s1_bpy_reg);
            s2_nx2_reg  <= PROD_W'(s1_nx_reg)  * PROD_W'(s1_nx_reg);
            s2_ny2_reg  <= PROD_W'(s1_ny_reg)  * PROD_W'(s1_ny_reg);
            s2_cr1_reg  <= PROD_W'(s1_nx_reg)  * PROD_W'(s1_pay_reg);
            s2_cr2_reg  <= PROD_W'(s1_ny_reg)  * PROD_W'(s1_pax_reg);

            s3_tag_reg   <= tag3_next;
            s3_cross_reg <= cross_sum;
            s3_nq_reg    <= nq_sum;

            s4_tag_reg <= s3_tag_reg;
            s4_nq_reg  <= s3_nq_reg;
            s4_u_reg   <= s3_cross_reg[SUM_W-1] ? U_W'(-s3_cross_reg) : U_W'(s3_cross_reg);

            s5_tag_reg <= s4_tag_reg;
            s5_nq_reg  <= s4_nq_reg;
            s5_sq_reg  <= N_W'(s4_u_reg) * N_W'(s4_u_reg);
        end
    end

    // ---------------- divider: floor(cross^2 / |n|^2) ----------------
    logic                      div_valid;
    logic [psd_pkg::QB-1:0]    div_q;
    psd_pkg::tag_t             div_tag;

    psd_div_pipe u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .enable    (advance),
        .in_valid  (s5_valid_reg),
        .dividend  (s5_sq_reg),
        .divisor   (s5_nq_reg),
        .in_tag    (s5_tag_reg),
        .out_valid (div_valid),
        .quotient  (div_q),
        .out_tag   (div_tag)
    );

    // ---------------- output register ----------------
    logic [SAT_W-1:0]  dist_sel;
    psd_pkg::result_t  result_next;
    logic              result_valid_reg;
    psd_pkg::result_t  result_reg;

    always_comb
    begin
        if (div_tag.kind == psd_pkg::CASE_INNER)
            dist_sel = SAT_W'(div_q);
        else
            dist_sel = SAT_W'(div_tag.dist_end);
        if (dist_sel > DIST_MAX)
            result_next.squared_distance = DIST_W'(DIST_MAX);
        else
            result_next.squared_distance = DIST_W'(dist_sel);
        result_next.closest_case = div_tag.kind;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (advance)
            result_valid_reg <= div_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // ---------------- assertions ----------------
    // accepted query must show up in the first stage
    `PSD_ASSERT_NEXT(a_accept_enters, clk, rst_n, query_valid && !query_stall, s1_valid_reg,
        "accepted query did not enter stage 1")
    // a held pipeline keeps its stage-3 occupancy
    `PSD_ASSERT_NEXT(a_hold_stage3, clk, rst_n, !advance,
        $stable(s3_valid_reg) && $stable(s3_tag_reg),
        "stage 3 changed while pipeline was held")
    // interior case never divides by zero
    `PSD_ASSERT_IMPLIES(a_inner_nonzero, clk, rst_n,
        s3_valid_reg && (s3_tag_reg.kind == psd_pkg::CASE_INNER), s3_nq_reg != '0,
        "interior case with zero segment length")

endmodule

@@ tb/point_segment_squared_distance_test.sv @@
// Self-checking testbench for point_segment_squared_distance.
// Depends on psd_pkg and the RTL of point_segment_squared_distance only.
module point_segment_squared_distance_test;

    timeunit 1ns;
    timeprecision 1ps;

    // Pipeline depth from the block header: arithmetic stages, one divider
    // stage per quotient bit, output register.
    localparam int     LATENCY     = 6 + 2 * psd_pkg::COORD_BITS + 2;
    localparam int     CYCLE_LIMIT = 400000;
    localparam int     PHASE_ITEMS = 93;
    localparam longint DIST_MAX    = (longint'(1) << psd_pkg::DIST_W) - 1;

    // One row of the directed table: the query and, where it can be read off
    // directly, the result it must give.
    typedef struct {
        psd_pkg::query_t  q;
        bit               known;
        psd_pkg::result_t want;
    } dir_row_t;

    logic                         clk;
    logic                         rst_n;
    logic                         query_valid;
    logic                         query_stall;
    psd_pkg::query_t              query;
    logic                         result_valid;
    logic                         result_stall = 1'b0;
    psd_pkg::result_t             result;
    logic                         cfg_valid;
    logic                         cfg_ready;
    logic [psd_pkg::THRESH_W-1:0] cfg_data;

    // Mirror of the degenerate-length threshold as last written.
    logic [psd_pkg::THRESH_W-1:0] zero_len_limit;
    logic [psd_pkg::THRESH_W-1:0] phase_limits [7];

    psd_pkg::result_t expected_results [$];
    dir_row_t         directed_rows [$];
    psd_pkg::result_t oldest_result;
    int       mismatch_count = 0;
    int       cycle_count    = 0;
    int       stall_hold     = 0;
    bit       no_idle        = 1'b0;   // when set, neither side inserts gaps

    point_segment_squared_distance u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .query_valid  (query_valid),
        .query_stall  (query_stall),
        .query        (query),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    // Watchdog: a hung handshake or a lost result ends the run here.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("*** FAILED ***");
        $finish;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH %s: got %0d, expected %0d (cycle %0d)", what, got, want, cycle_count);
        mismatch_count++;
    endtask

    // Mostly back-to-back, some short gaps, a few long ones.
    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    // Expected result of one query under the given threshold. Endpoint cases
    // are exact; the interior case is floor(cross^2 / |n|^2). With 12-bit
    // coordinates cross^2 stays below 2^51, so 64-bit math is exact.
    function automatic psd_pkg::result_t predict_distance(
        input psd_pkg::query_t q, input logic [psd_pkg::THRESH_W-1:0] thr);
        longint ax, ay, bx, by, px, py;
        longint nx, ny, pax, pay, bpx, bpy;
        longint nq, cr, sq_dist;
        logic [1:0] kind;
        psd_pkg::result_t r;
        ax  = $signed(q.a_x);
        ay  = $signed(q.a_y);
        bx  = $signed(q.b_x);
        by  = $signed(q.b_y);
        px  = $signed(q.p_x);
        py  = $signed(q.p_y);
        nx  = bx - ax;
        ny  = by - ay;
        pax = ax - px;
        pay = ay - py;
        bpx = px - bx;
        bpy = py - by;
        // order matters: before a, then beyond b, then degenerate, then interior
        if (nx * pax + ny * pay > 0)
        begin
            sq_dist = pax * pax + pay * pay;
            kind    = psd_pkg::CASE_A;
        end
        else if (nx * bpx + ny * bpy > 0)
        begin
            sq_dist = bpx * bpx + bpy * bpy;
            kind    = psd_pkg::CASE_B;
        end
        else
        begin
            nq = nx * nx + ny * ny;
            if (nq <= longint'(thr))
            begin
                // zero-length segment always lands here, so no divide by zero
                sq_dist = pax * pax + pay * pay;
                kind    = psd_pkg::CASE_DEGEN;
            end
            else
            begin
                cr = nx * pay - ny * pax;
                if (cr < 0)
                    cr = -cr;
                sq_dist = (cr * cr) / nq;
                kind    = psd_pkg::CASE_INNER;
            end
        end
        if (sq_dist > DIST_MAX)
            sq_dist = DIST_MAX;
        r.squared_distance = sq_dist[psd_pkg::DIST_W-1:0];
        r.closest_case     = kind;
        return r;
    endfunction

    function automatic psd_pkg::query_t make_query(input int ax, input int ay,
                                                   input int bx, input int by,
                                                   input int px, input int py);
        psd_pkg::query_t q;
        // bits above the coordinate width wrap away
        q.a_x = ax[psd_pkg::COORD_BITS-1:0];
        q.a_y = ay[psd_pkg::COORD_BITS-1:0];
        q.b_x = bx[psd_pkg::COORD_BITS-1:0];
        q.b_y = by[psd_pkg::COORD_BITS-1:0];
        q.p_x = px[psd_pkg::COORD_BITS-1:0];
        q.p_y = py[psd_pkg::COORD_BITS-1:0];
        return q;
    endfunction

    task automatic add_row(input int ax, input int ay, input int bx, input int by,
                           input int px, input int py, input bit known,
                           input int want_dist, input logic [1:0] kind);
        dir_row_t row;
        row.q                     = make_query(ax, ay, bx, by, px, py);
        row.known                 = known;
        row.want.squared_distance = want_dist[psd_pkg::DIST_W-1:0];
        row.want.closest_case     = kind;
        directed_rows.push_back(row);
    endtask

    function automatic int spread(input int k);
        return int'($urandom_range(2 * k)) - k;
    endfunction

    function automatic int pick_extreme();
        case ($urandom_range(6))
            0:       return -2048;
            1:       return -2047;
            2:       return -1;
            3:       return 0;
            4:       return 1;
            5:       return 2046;
            default: return 2047;
        endcase
    endfunction

    // Random query. Most land near a segment so all four cases show up;
    // the rest is raw noise and extreme corners.
    function automatic psd_pkg::query_t random_query();
        int ax, ay, bx, by, px, py, t, r;
        psd_pkg::query_t q;
        r = $urandom_range(99);
        if (r < 15)
        begin
            q = psd_pkg::query_t'({$urandom, $urandom, $urandom});
        end
        else if (r < 25)
        begin
            q = make_query(pick_extreme(), pick_extreme(), pick_extreme(),
                           pick_extreme(), pick_extreme(), pick_extreme());
        end
        else if (r < 45)
        begin
            // short segment: exercises the degenerate threshold
            ax = spread(1900);
            ay = spread(1900);
            bx = ax + spread(12);
            by = ay + spread(12);
            q  = make_query(ax, ay, bx, by, ax + spread(40), ay + spread(40));
        end
        else if (r < 85)
        begin
            // point near the segment body
            ax = spread(1500);
            ay = spread(1500);
            bx = spread(1500);
            by = spread(1500);
            t  = $urandom_range(16);
            px = ax + ((bx - ax) * t) / 16 + spread(60);
            py = ay + ((by - ay) * t) / 16 + spread(60);
            q  = make_query(ax, ay, bx, by, px, py);
        end
        else
        begin
            // point just around an endpoint
            ax = spread(2000);
            ay = spread(2000);
            bx = spread(2000);
            by = spread(2000);
            if ($urandom_range(1))
                q = make_query(ax, ay, bx, by, bx + spread(8), by + spread(8));
            else
                q = make_query(ax, ay, bx, by, ax + spread(8), ay + spread(8));
        end
        return q;
    endfunction

    // Drive one query transaction; the expectation is queued at the edge
    // that accepts it. Valid stays high into the next call when no gap follows.
    task automatic send_query(input psd_pkg::query_t q, input psd_pkg::result_t want);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            query_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        query_valid <= 1'b1;
        query       <= q;
        do
            @(posedge clk);
        while (query_stall);
        expected_results.push_back(want);
    endtask

    task automatic send_checked(input psd_pkg::query_t q);
        send_query(q, predict_distance(q, zero_len_limit));
    endtask

    // Sender holds off until every queued expectation has been matched.
    task automatic drain_results();
        query_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_threshold(input logic [psd_pkg::THRESH_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid      <= 1'b0;
        zero_len_limit  = value;
    endtask

    // Result-side backpressure: random stall runs, free runs in between.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            stall_hold   <= 0;
        end
        else if (stall_hold != 0)
        begin
            stall_hold <= stall_hold - 1;
        end
        else if (result_stall || no_idle)
        begin
            result_stall <= 1'b0;
            stall_hold   <= $urandom_range(6);
        end
        else
        begin
            stall_hold   <= pick_gap();
            result_stall <= ($urandom_range(99) >= 55);
        end
    end

    // Scoreboard: each accepted result against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_results.size() == 0)
            begin
                report_mismatch("unexpected result transaction", result.squared_distance, 0);
            end
            else
            begin
                oldest_result = expected_results.pop_front();
                if (result.squared_distance !== oldest_result.squared_distance)
                    report_mismatch("squared_distance", result.squared_distance,
                                    oldest_result.squared_distance);
                if (result.closest_case !== oldest_result.closest_case)
                    report_mismatch("closest_case", result.closest_case,
                                    oldest_result.closest_case);
            end
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        query_valid    = 1'b0;
        query          = '0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        zero_len_limit = '0;    // reset value of the threshold

        // Directed table, run with the reset threshold of zero.
        add_row(0, 0, 0, 0, 0, 0, 1, 0, psd_pkg::CASE_DEGEN);          // all zero
        add_row(-2048, -2048, 2047, 2047, -2048, -2048, 1, 0,
                psd_pkg::CASE_INNER);                                  // p on a
        add_row(0, 0, 10, 0, -5, 0, 1, 25, psd_pkg::CASE_A);           // before a
        add_row(0, 0, 10, 0, 15, 0, 1, 25, psd_pkg::CASE_B);           // beyond b
        add_row(0, 0, 10, 0, 5, 3, 1, 9, psd_pkg::CASE_INNER);
        add_row(-2048, -2048, -2048, -2048, 2047, 2047, 1, 33538050, psd_pkg::CASE_DEGEN);
        add_row(0, 0, 3, 1, 1, 2, 1, 2, psd_pkg::CASE_INNER);          // 25/10 floors
        add_row(0, 0, 10, 0, 10, 0, 1, 0, psd_pkg::CASE_INNER);        // p on b
        add_row(5, 5, 5, 5, 5, 5, 1, 0, psd_pkg::CASE_DEGEN);          // all coincident
        add_row(0, 0, 0, 0, -1, -1, 1, 2, psd_pkg::CASE_DEGEN);
        add_row(-2048, -2048, 0, 0, 2047, 2047, 1, 8380418, psd_pkg::CASE_B);
        add_row(-2048, -2048, 2047, -2048, 0, 2047, 1, 16769025, psd_pkg::CASE_INNER);
        add_row(2047, -2048, 2047, 2047, -2048, -2048, 0, 0, psd_pkg::CASE_A);
        add_row(2047, 2047, -2048, -2048, -2048, 2047, 0, 0, psd_pkg::CASE_A);
        add_row(-2048, 0, 2047, 0, 0, 2047, 0, 0, psd_pkg::CASE_A);
        add_row(2047, 2047, 2047, 2047, -2048, 2047, 0, 0, psd_pkg::CASE_A);
        add_row(-2048, 2047, 2047, -2048, 2047, 2047, 0, 0, psd_pkg::CASE_A);
        add_row(100, -200, -300, 400, -2048, -2048, 0, 0, psd_pkg::CASE_A);
        add_row(-1, -1, 1, 1, 2047, -2048, 0, 0, psd_pkg::CASE_A);

        phase_limits[0] = 25'd100;
        phase_limits[1] = 25'd33538050;
        phase_limits[2] = '1;
        phase_limits[3] = 25'd1;
        phase_limits[4] = 25'($urandom_range(5000));
        phase_limits[5] = 25'h0AAAAAA;
        phase_limits[6] = '0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].known)
                send_query(directed_rows[i].q, directed_rows[i].want);
            else
                send_checked(directed_rows[i].q);
        end

        for (int ph = 0; ph < 7; ph++)
        begin
            // threshold only changes with the pipeline empty
            drain_results();
            write_threshold(phase_limits[ph]);
            no_idle = (ph == 3);

            if (phase_limits[ph] == 25'd100)
            begin
                // |n|^2 exactly at the threshold, then one above it
                send_checked(make_query(0, 0, 6, 8, 3, 4));
                send_checked(make_query(0, 0, 10, 1, 5, -7));
                send_checked(make_query(-700, 300, -700, 300, 900, -1200));
            end

            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                if (k == 45)
                    drain_results();
                send_checked(random_query());
            end
        end
        no_idle = 1'b0;

        drain_results();
        // catch any stray result that trails the last expected one
        repeat (LATENCY + 8) @(posedge clk);
        if (expected_results.size() != 0)
            report_mismatch("results never delivered", 0, expected_results.size());

        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
